// ----- hw/rtl/cau_pkg.sv -----
// Shared constants, codes and opcode decode for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  // Default datapath shape and fixed port widths
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PORT_BITS     = 32;
  localparam int unsigned OPC_BITS      = 3;
  localparam int unsigned STAT_BITS     = 2;
  localparam int unsigned KIND_BITS     = 3;
  localparam int unsigned IN_DEPTH      = 4;
  localparam int unsigned OUT_DEPTH     = 2;

  // Opcodes as they arrive on the port
  localparam logic [OPC_BITS-1:0] OPC_ADD = 3'd0;
  localparam logic [OPC_BITS-1:0] OPC_SUB = 3'd1;
  localparam logic [OPC_BITS-1:0] OPC_MUL = 3'd2;
  localparam logic [OPC_BITS-1:0] OPC_DIV = 3'd3;
  localparam logic [OPC_BITS-1:0] OPC_EQ  = 3'd4;
  localparam logic [OPC_BITS-1:0] OPC_NE  = 3'd5;

  // Work class handed from the front to the back
  typedef enum logic [KIND_BITS-1:0] {
    KIND_NONE,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_EQ,
    KIND_NE
  } kind_e;

  // Result status codes
  typedef enum logic [STAT_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // Opcode to work class; unused opcodes give an all-zero result
  function automatic kind_e decode_op(logic [OPC_BITS-1:0] op);
    kind_e k;
    unique case (op)
      OPC_ADD: k = KIND_ADD;
      OPC_SUB: k = KIND_SUB;
      OPC_MUL: k = KIND_MUL;
      OPC_DIV: k = KIND_DIV;
      OPC_EQ:  k = KIND_EQ;
      OPC_NE:  k = KIND_NE;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/complex_arith_unit_core.sv -----
// Top level of the complex arithmetic unit: command queue, datapath and result queue.
`default_nettype none

// Complex add, subtract, multiply, divide and compare on signed fixed-point
// operands (WORD_BITS wide, FRAC_BITS fraction bits; low WORD_BITS of each
// port used, results sign-extended). Words go in through push_i/full_o and
// come out through empty_o/pop_i in order. The unit takes one word per clock
// cycle sustained while the result queue has room; every operation, not only
// divide, runs through the same pipeline: the command queue, the first
// arithmetic stage, two more arithmetic stages, WORD_BITS + 1 divider stages
// (the first checks for a quotient overflow, each of the others resolves one
// quotient bit) and the write into the result queue. A full result queue
// holds the whole datapath; the command queue keeps taking words until it fills.
module complex_arith_unit_core #(
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [cau_pkg::OPC_BITS-1:0]   opcode_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]  lhs_real_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]  lhs_imag_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]  rhs_real_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]  rhs_imag_i,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [cau_pkg::PORT_BITS-1:0]       result_real_o,
  output logic [cau_pkg::PORT_BITS-1:0]       result_imag_o,
  output logic                                compare_true_o,
  output logic [cau_pkg::STAT_BITS-1:0]       status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PB = cau_pkg::PORT_BITS;
  localparam int unsigned RW = 2 * W + 1 + cau_pkg::STAT_BITS;

  logic                          cmd_vld, cmd_pop;
  cau_pkg::kind_e                kind;
  logic signed [W-1:0]           a, b, c, d;
  logic                          out_full, out_push, out_pop;
  logic [W-1:0]                  re, im, q_re, q_im;
  logic                          cmp, q_cmp;
  cau_pkg::status_e              st;
  logic [cau_pkg::STAT_BITS-1:0] q_st;
  logic [RW-1:0]                 out_wdata, out_rdata;

  cau_front #(
    .WORD_BITS(W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .opcode_i  (opcode_i),
    .lhs_real_i(lhs_real_i),
    .lhs_imag_i(lhs_imag_i),
    .rhs_real_i(rhs_real_i),
    .rhs_imag_i(rhs_imag_i),
    .vld_o     (cmd_vld),
    .pop_i     (cmd_pop),
    .kind_o    (kind),
    .a_o       (a),
    .b_o       (b),
    .c_o       (c),
    .d_o       (d)
  );

  cau_back #(
    .WORD_BITS(W),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (cmd_vld),
    .in_pop_o  (cmd_pop),
    .kind_i    (kind),
    .a_i       (a),
    .b_i       (b),
    .c_i       (c),
    .d_i       (d),
    .out_full_i(out_full),
    .out_push_o(out_push),
    .re_o      (re),
    .im_o      (im),
    .cmp_o     (cmp),
    .status_o  (st)
  );

  // Result queue
  assign out_wdata = {re, im, cmp, st};
  assign out_pop   = pop_i && !empty_o;

  cau_fifo #(
    .DATA_W(RW),
    .DEPTH (cau_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .full_o (out_full),
    .pop_i  (out_pop),
    .rdata_o(out_rdata),
    .empty_o(empty_o)
  );

  assign {q_re, q_im, q_cmp, q_st} = out_rdata;
  assign result_real_o  = PB'($signed(q_re));
  assign result_imag_o  = PB'($signed(q_im));
  assign compare_true_o = q_cmp;
  assign status_o       = q_st;

  // Result word consistency
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == cau_pkg::ST_DIVZ) |->
      (result_real_o == '0 && result_imag_o == '0 && !compare_true_o))
    else $error("divide by zero word carries nonzero parts");
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && compare_true_o) |->
      (status_o == cau_pkg::ST_OK && result_real_o == '0 && result_imag_o == '0))
    else $error("compare word carries parts or status");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o == cau_pkg::ST_OK || status_o == cau_pkg::ST_SAT ||
                  status_o == cau_pkg::ST_DIVZ))
    else $error("result word carries an unknown status code");

endmodule

`default_nettype wire

// ----- hw/rtl/cau_fifo.sv -----
// Small flop-based FIFO used for the command queue and the result queue.
`default_nettype none

module cau_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic      [DATA_W-1:0] rdata_o,
  output logic                   empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     rptr_q, rptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wptr_d = push_i ? wptr_q + AW'(1) : wptr_q;
    rptr_d = pop_i  ? rptr_q + AW'(1) : rptr_q;
    cnt_d  = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);

  // Callers gate their strobes with the flags
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("fifo write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("fifo read while empty");

endmodule

`default_nettype wire

// ----- hw/rtl/cau_front.sv -----
// Front end: takes command words, classifies the opcode and queues the work.
`default_nettype none

module cau_front #(
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  output logic                                    full_o,
  input  wire logic [cau_pkg::OPC_BITS-1:0]       opcode_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]      lhs_real_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]      lhs_imag_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]      rhs_real_i,
  input  wire logic [cau_pkg::PORT_BITS-1:0]      rhs_imag_i,
  output logic                                    vld_o,
  input  wire logic                               pop_i,
  output cau_pkg::kind_e                          kind_o,
  output logic signed [WORD_BITS-1:0]             a_o,
  output logic signed [WORD_BITS-1:0]             b_o,
  output logic signed [WORD_BITS-1:0]             c_o,
  output logic signed [WORD_BITS-1:0]             d_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned DW = cau_pkg::KIND_BITS + 4 * W;

  logic                            wr;
  logic                            empty;
  logic [DW-1:0]                   wdata;
  logic [DW-1:0]                   rdata;
  logic [cau_pkg::KIND_BITS-1:0]   kind_bits;

  // Classify and keep only the low word of each operand
  assign wr    = push_i && !full_o;
  assign wdata = {cau_pkg::decode_op(opcode_i), lhs_real_i[W-1:0], lhs_imag_i[W-1:0],
                  rhs_real_i[W-1:0], rhs_imag_i[W-1:0]};

  cau_fifo #(
    .DATA_W(DW),
    .DEPTH (cau_pkg::IN_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (wr),
    .wdata_i(wdata),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(rdata),
    .empty_o(empty)
  );

  assign {kind_bits, a_o, b_o, c_o, d_o} = rdata;
  assign kind_o = cau_pkg::kind_e'(kind_bits);
  assign vld_o  = !empty;

endmodule

`default_nettype wire

// ----- hw/rtl/cau_div.sv -----
// Pipelined restoring divider: two quotients of floor(num * 2^F / den), one bit per stage after an overflow stage.
`default_nettype none

module cau_div #(
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned SB_W      = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic [2*WORD_BITS-1:0]   num_re_i,
  input  wire logic [2*WORD_BITS-1:0]   num_im_i,
  input  wire logic [2*WORD_BITS-1:0]   den_i,
  input  wire logic [SB_W-1:0]          sb_i,
  output logic                          vld_o,
  output logic [WORD_BITS-1:0]          q_re_o,
  output logic [WORD_BITS-1:0]          q_im_o,
  output logic                          ovf_re_o,
  output logic                          ovf_im_o,
  output logic [SB_W-1:0]               sb_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned P  = 2 * W;
  localparam int unsigned NS = W + 1;
  localparam int unsigned RW = P + FRAC_BITS;
  localparam int unsigned XW = 3 * W + FRAC_BITS + 1;

  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   ore_q;
  logic [NS-1:0]   oim_q;
  logic [RW-1:0]   rre_q [NS];
  logic [RW-1:0]   rim_q [NS];
  logic [P-1:0]    den_q [NS];
  logic [W-1:0]    qre_q [NS];
  logic [W-1:0]    qim_q [NS];
  logic [SB_W-1:0] sb_q  [NS];

  // Stage 0 checks for a quotient of 2^W or more; stage s then settles bit W-s
  for (genvar s = 0; s < NS; s++) begin : g_stg
    localparam int unsigned K = W - s;

    logic            vld_in, ore_in, oim_in;
    logic [RW-1:0]   rre_in, rim_in, rre_d, rim_d;
    logic [P-1:0]    den_in;
    logic [W-1:0]    qre_in, qim_in, qre_d, qim_d;
    logic [SB_W-1:0] sb_in;
    logic [XW-1:0]   dsh, dre, dim;
    logic            ge_re, ge_im, ore_d, oim_d;

    if (s == 0) begin : g_head
      assign vld_in = vld_i;
      assign ore_in = 1'b0;
      assign oim_in = 1'b0;
      assign rre_in = RW'(num_re_i) << FRAC_BITS;
      assign rim_in = RW'(num_im_i) << FRAC_BITS;
      assign den_in = den_i;
      assign qre_in = '0;
      assign qim_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_link
      assign vld_in = vld_q[s-1];
      assign ore_in = ore_q[s-1];
      assign oim_in = oim_q[s-1];
      assign rre_in = rre_q[s-1];
      assign rim_in = rim_q[s-1];
      assign den_in = den_q[s-1];
      assign qre_in = qre_q[s-1];
      assign qim_in = qim_q[s-1];
      assign sb_in  = sb_q[s-1];
    end

    // Trial subtract of the shifted divisor
    assign dsh   = XW'(den_in) << K;
    assign dre   = XW'(rre_in) - dsh;
    assign dim   = XW'(rim_in) - dsh;
    assign ge_re = !dre[XW-1];
    assign ge_im = !dim[XW-1];

    if (s == 0) begin : g_ovf
      assign ore_d = ge_re;
      assign oim_d = ge_im;
      assign rre_d = rre_in;
      assign rim_d = rim_in;
      assign qre_d = qre_in;
      assign qim_d = qim_in;
    end else begin : g_bit
      always_comb begin
        ore_d = ore_in;
        oim_d = oim_in;
        rre_d = rre_in;
        rim_d = rim_in;
        qre_d = qre_in;
        qim_d = qim_in;
        if (ge_re && !ore_in) begin
          rre_d    = dre[RW-1:0];
          qre_d[K] = 1'b1;
        end
        if (ge_im && !oim_in) begin
          rim_d    = dim[RW-1:0];
          qim_d[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ore_q[s] <= ore_d;
        oim_q[s] <= oim_d;
        rre_q[s] <= rre_d;
        rim_q[s] <= rim_d;
        den_q[s] <= den_in;
        qre_q[s] <= qre_d;
        qim_q[s] <= qim_d;
        sb_q[s]  <= sb_in;
      end
    end
  end

  assign vld_o    = vld_q[NS-1];
  assign q_re_o   = qre_q[NS-1];
  assign q_im_o   = qim_q[NS-1];
  assign ovf_re_o = ore_q[NS-1];
  assign ovf_im_o = oim_q[NS-1];
  assign sb_o     = sb_q[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cau_back.sv -----
// Back end: products, sums, magnitudes, division and saturation, one word per cycle unless the result queue is full.
`default_nettype none

module cau_back #(
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_vld_i,
  output logic                               in_pop_o,
  input  wire cau_pkg::kind_e                kind_i,
  input  wire logic signed [WORD_BITS-1:0]   a_i,
  input  wire logic signed [WORD_BITS-1:0]   b_i,
  input  wire logic signed [WORD_BITS-1:0]   c_i,
  input  wire logic signed [WORD_BITS-1:0]   d_i,
  input  wire logic                          out_full_i,
  output logic                               out_push_o,
  output logic [WORD_BITS-1:0]               re_o,
  output logic [WORD_BITS-1:0]               im_o,
  output logic                               cmp_o,
  output cau_pkg::status_e                   status_o
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned P    = 2 * W;
  localparam int unsigned X    = P + 1;
  localparam int unsigned S    = W + 1;
  localparam int unsigned SB_W = cau_pkg::KIND_BITS + 2 + 2 * P + 2;
  localparam logic [P-1:0] HALF = P'(1) << (W - 1);

  logic adv;
  logic last_vld;

  // Stage 1: products, add/sub, equality
  logic                    s1_vld_q;
  cau_pkg::kind_e          s1_kind_q;
  logic signed [P-1:0]     ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic signed [S-1:0]     sre_q, sim_q;
  logic                    s1_eq_q;

  // Stage 2: combined parts and divisor
  logic                    s2_vld_q;
  cau_pkg::kind_e          s2_kind_q;
  logic signed [X-1:0]     x_re_q, x_im_q;
  logic [P-1:0]            s2_den_q;
  logic                    s2_eq_q;
  logic signed [X-1:0]     x_re_d, x_im_d;

  // Stage 3: sign and magnitude
  logic                    s3_vld_q;
  cau_pkg::kind_e          s3_kind_q;
  logic                    neg_re_q, neg_im_q;
  logic [P-1:0]            mag_re_q, mag_im_q;
  logic [P-1:0]            s3_den_q;
  logic                    s3_eq_q, divz_q;
  logic [X-1:0]            abs_re, abs_im;
  logic [P-1:0]            mag_re_d, mag_im_d;

  // Divider and final fields
  logic [SB_W-1:0]               sb_in, sb_out;
  logic [W-1:0]                  q_re, q_im;
  logic                          ovf_re, ovf_im;
  logic [cau_pkg::KIND_BITS-1:0] f_kind_bits;
  cau_pkg::kind_e                f_kind;
  logic                          f_neg_re, f_neg_im, f_eq, f_divz, f_is_div;
  logic [P-1:0]                  f_mag_re, f_mag_im;
  logic [W:0]                    fin_re, fin_im;

  // The whole back end holds only when its last word cannot leave
  assign adv        = !(last_vld && out_full_i);
  assign in_pop_o   = adv && in_vld_i;
  assign out_push_o = adv && last_vld;

  // Stage 1, and the valid bits of the later stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= kind_i;
      ac_q      <= P'(a_i) * P'(c_i);
      bd_q      <= P'(b_i) * P'(d_i);
      ad_q      <= P'(a_i) * P'(d_i);
      bc_q      <= P'(b_i) * P'(c_i);
      cc_q      <= P'(c_i) * P'(c_i);
      dd_q      <= P'(d_i) * P'(d_i);
      sre_q     <= (kind_i == cau_pkg::KIND_SUB) ? S'(a_i) - S'(c_i) : S'(a_i) + S'(c_i);
      sim_q     <= (kind_i == cau_pkg::KIND_SUB) ? S'(b_i) - S'(d_i) : S'(b_i) + S'(d_i);
      s1_eq_q   <= (a_i == c_i) && (b_i == d_i);
    end
  end

  // Stage 2: pick the two signed parts for the operation
  always_comb begin
    case (s1_kind_q) inside
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
        x_re_d = X'(sre_q);
        x_im_d = X'(sim_q);
      end
      cau_pkg::KIND_MUL: begin
        x_re_d = X'(ac_q) - X'(bd_q);
        x_im_d = X'(ad_q) + X'(bc_q);
      end
      cau_pkg::KIND_DIV: begin
        x_re_d = X'(ac_q) + X'(bd_q);
        x_im_d = X'(bc_q) - X'(ad_q);
      end
      default: begin
        x_re_d = '0;
        x_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_kind_q <= s1_kind_q;
      x_re_q    <= x_re_d;
      x_im_q    <= x_im_d;
      s2_den_q  <= P'(cc_q) + P'(dd_q);
      s2_eq_q   <= s1_eq_q;
    end
  end

  // Stage 3: magnitudes; the product drops its fraction toward zero
  assign abs_re = x_re_q[X-1] ? X'(-x_re_q) : X'(x_re_q);
  assign abs_im = x_im_q[X-1] ? X'(-x_im_q) : X'(x_im_q);

  always_comb begin
    if (s2_kind_q == cau_pkg::KIND_MUL) begin
      mag_re_d = P'(abs_re >> FRAC_BITS);
      mag_im_d = P'(abs_im >> FRAC_BITS);
    end else begin
      mag_re_d = abs_re[P-1:0];
      mag_im_d = abs_im[P-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_kind_q <= s2_kind_q;
      neg_re_q  <= x_re_q[X-1];
      neg_im_q  <= x_im_q[X-1];
      mag_re_q  <= mag_re_d;
      mag_im_q  <= mag_im_d;
      s3_den_q  <= s2_den_q;
      s3_eq_q   <= s2_eq_q;
      divz_q    <= (s2_kind_q == cau_pkg::KIND_DIV) && (s2_den_q == '0);
    end
  end

  // Every word rides through the divider so order is kept
  assign sb_in = {s3_kind_q, neg_re_q, neg_im_q, mag_re_q, mag_im_q, s3_eq_q, divz_q};

  cau_div #(
    .WORD_BITS(W),
    .FRAC_BITS(FRAC_BITS),
    .SB_W     (SB_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s3_vld_q),
    .num_re_i(mag_re_q),
    .num_im_i(mag_im_q),
    .den_i   (s3_den_q),
    .sb_i    (sb_in),
    .vld_o   (last_vld),
    .q_re_o  (q_re),
    .q_im_o  (q_im),
    .ovf_re_o(ovf_re),
    .ovf_im_o(ovf_im),
    .sb_o    (sb_out)
  );

  assign {f_kind_bits, f_neg_re, f_neg_im, f_mag_re, f_mag_im, f_eq, f_divz} = sb_out;
  assign f_kind   = cau_pkg::kind_e'(f_kind_bits);
  assign f_is_div = (f_kind == cau_pkg::KIND_DIV);

  // Clamp one part to the signed word range; returns {saturated, value}
  function automatic logic [W:0] clamp_part(logic neg, logic [P-1:0] mag, logic is_div,
                                            logic [W-1:0] q, logic ovf);
    logic [P-1:0] eff, lim, cl, cl_n;
    logic         over;
    eff  = is_div ? P'(q) : mag;
    lim  = neg ? HALF : HALF - P'(1);
    over = (is_div && ovf) || (eff > lim);
    cl   = over ? lim : eff;
    cl_n = -cl;
    return {over, neg ? cl_n[W-1:0] : cl[W-1:0]};
  endfunction

  assign fin_re = clamp_part(f_neg_re, f_mag_re, f_is_div, q_re, ovf_re);
  assign fin_im = clamp_part(f_neg_im, f_mag_im, f_is_div, q_im, ovf_im);

  // Result word
  always_comb begin
    re_o     = '0;
    im_o     = '0;
    cmp_o    = 1'b0;
    status_o = cau_pkg::ST_OK;
    case (f_kind) inside
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_MUL, cau_pkg::KIND_DIV: begin
        if (f_divz) begin
          status_o = cau_pkg::ST_DIVZ;
        end else begin
          re_o     = fin_re[W-1:0];
          im_o     = fin_im[W-1:0];
          status_o = (fin_re[W] || fin_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::KIND_EQ: cmp_o = f_eq;
      cau_pkg::KIND_NE: cmp_o = !f_eq;
      default: cmp_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
